// ===== rtl/pfa_pkg.sv =====
// Shared types and constants for the page frame allocator.
// Used by every module under rtl/ except pfa_mem; depends on nothing else.
package pfa_pkg;

  localparam int FRAME_W = 40;
  localparam int CNT_W   = 13;
  localparam int VAL_W   = 16;
  localparam int ZLIM_W  = 7;
  localparam int LEN_W   = 17;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RETURN  = 3'd2,
    CMD_MARK    = 3'd3,
    CMD_INCREF  = 3'd4,
    CMD_READREF = 3'd5,
    CMD_ZERO    = 3'd6,
    CMD_COUNT   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOFRAME  = 2'd1,
    STS_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_FIN
  } state_t;

  typedef enum logic {
    PH_SEARCH,
    PH_APPLY
  } phase_t;

  typedef struct packed {
    status_t              status;
    logic [FRAME_W-1:0]   frame;
    logic [VAL_W-1:0]     value;
    logic [CNT_W-1:0]     unused;
    logic [CNT_W-1:0]     zeroed;
    logic                 last;
  } result_t;

endpackage

// ===== rtl/pfa_mem.sv =====
// Frame table storage: one write port, one read port with registered data.
// Depends on nothing; the entry layout is set by the engine.
module pfa_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 58,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pfa_out_buf.sv =====
// Output register between the engine and the result channel.
// Depends on pfa_pkg for the result struct.
module pfa_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  pfa_pkg::result_t  res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pfa_pkg::result_t  out_res
);
  import pfa_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

// ===== rtl/pfa_engine.sv =====
// Command sequencer: scans the frame table one entry at a time, applies
// read-modify-write updates and keeps the frame counters. Depends on pfa_pkg.
module pfa_engine #(
  parameter int TABLE_DEPTH    = 4096,
  parameter int REF_WIDTH      = 16,
  parameter int MAX_ZERO_BURST = 64,
  parameter int AW             = 12,
  parameter int EW             = 58
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [pfa_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_command,
  input  logic [11:0]               in_entry_index,
  input  logic [pfa_pkg::FRAME_W-1:0] in_frame_number,
  input  logic                      in_entry_free,
  input  logic [3:0]                in_order,
  input  logic                      in_clean_only,
  input  logic [pfa_pkg::ZLIM_W-1:0] in_zero_limit,
  input  logic [1:0]                in_dirty_select,
  output logic                      mem_rd_en,
  output logic [AW-1:0]             mem_rd_addr,
  input  logic [EW-1:0]             mem_rd_data,
  output logic                      mem_wr_en,
  output logic [AW-1:0]             mem_wr_addr,
  output logic [EW-1:0]             mem_wr_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output pfa_pkg::result_t          res
);
  import pfa_pkg::*;

  localparam int NW = AW + 1;
  localparam int CW = (NW > ZLIM_W) ? NW : ZLIM_W;
  localparam int SAT_MAX = 32767;

  // Entry layout: frame in the low bits, then ref count, free, dirty.
  logic [FRAME_W-1:0]   e_frame;
  logic [REF_WIDTH-1:0] e_ref;
  logic                 e_free;
  logic                 e_dirty;
  logic [REF_WIDTH-1:0] dec_ref;

  assign e_frame = mem_rd_data[FRAME_W-1:0];
  assign e_ref   = mem_rd_data[FRAME_W +: REF_WIDTH];
  assign e_free  = mem_rd_data[FRAME_W+REF_WIDTH];
  assign e_dirty = mem_rd_data[FRAME_W+REF_WIDTH+1];
  assign dec_ref = e_ref - REF_WIDTH'(1);

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]   unused_r, unused_nxt;
  logic [CNT_W-1:0]   zeroed_r, zeroed_nxt;
  logic               pend_v_r, pend_v_nxt;
  result_t            pend_r, pend_nxt;
  logic [FRAME_W-1:0] key_r, key_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [LEN_W-1:0]   run_r, run_nxt;
  logic               zonly_r, zonly_nxt;
  logic [ZLIM_W-1:0]  zlim_r, zlim_nxt;
  logic [1:0]         dsel_r, dsel_nxt;
  logic [NW-1:0]      live_r, live_nxt;
  logic [NW-1:0]      j_r, j_nxt;
  logic [NW-1:0]      start_r, start_nxt;
  logic               has_start_r, has_start_nxt;
  logic               prev_ok_r, prev_ok_nxt;
  logic [FRAME_W-1:0] prev_frame_r, prev_frame_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;

  logic               scan_done;
  logic               contig;
  logic               start_ok;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    cmd_nxt         = cmd_r;
    entry_count_nxt = entry_count_r;
    unused_nxt      = unused_r;
    zeroed_nxt      = zeroed_r;
    pend_v_nxt      = pend_v_r;
    pend_nxt        = pend_r;
    key_nxt         = key_r;
    len_nxt         = len_r;
    remain_nxt      = remain_r;
    run_nxt         = run_r;
    zonly_nxt       = zonly_r;
    zlim_nxt        = zlim_r;
    dsel_nxt        = dsel_r;
    live_nxt        = live_r;
    j_nxt           = j_r;
    start_nxt       = start_r;
    has_start_nxt   = has_start_r;
    prev_ok_nxt     = prev_ok_r;
    prev_frame_nxt  = prev_frame_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    val_nxt         = val_r;
    res_frame_nxt   = res_frame_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = j_r[AW-1:0];
    mem_wr_en       = 1'b0;
    mem_wr_addr     = j_r[AW-1:0];
    mem_wr_data     = mem_rd_data;
    res_valid       = 1'b0;
    res             = '{status: STS_OK, frame: '0, value: '0, unused: unused_r,
                        zeroed: zeroed_r, last: 1'b1};
    scan_done       = (32'(j_r) >= 32'(live_r)) ||
                      (phase_r == PH_APPLY && remain_r == '0) ||
                      (cmd_r == CMD_ZERO && cnt_r >= CW'(zlim_r));
    contig          = prev_ok_r && (e_frame == FRAME_W'(prev_frame_r + FRAME_W'(1)));
    start_ok        = !zonly_r || !e_dirty;

    if (cfg_wr_en) begin
      entry_count_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt       = cmd_t'(in_command);
          key_nxt       = in_frame_number;
          len_nxt       = LEN_W'(1) << in_order;
          zonly_nxt     = in_clean_only;
          zlim_nxt      = (32'(in_zero_limit) > MAX_ZERO_BURST) ?
                          ZLIM_W'(MAX_ZERO_BURST) : in_zero_limit;
          dsel_nxt      = in_dirty_select;
          live_nxt      = (32'(entry_count_r) < TABLE_DEPTH) ?
                          NW'(entry_count_r) : NW'(TABLE_DEPTH);
          j_nxt         = '0;
          phase_nxt     = PH_SEARCH;
          has_start_nxt = 1'b0;
          prev_ok_nxt   = 1'b0;
          run_nxt       = '0;
          remain_nxt    = '0;
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          pend_v_nxt    = 1'b0;
          val_nxt       = '0;
          res_frame_nxt = '0;
          if (cmd_t'(in_command) == CMD_LOAD) begin
            if (32'(in_entry_index) < TABLE_DEPTH) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = AW'(in_entry_index);
              mem_wr_data = {!in_entry_free, in_entry_free,
                             in_entry_free ? REF_WIDTH'(0) : REF_WIDTH'(1),
                             in_frame_number};
              if (in_entry_free) begin
                unused_nxt = unused_r + CNT_W'(1);
                zeroed_nxt = zeroed_r + CNT_W'(1);
              end
            end
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        if (scan_done) begin
          state_nxt = S_FIN;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = S_EV;
        end
      end

      S_EV: begin
        state_nxt = S_RD;
        case (cmd_r)
          CMD_ALLOC: begin
            if (phase_r == PH_SEARCH) begin
              if (!e_free) begin
                prev_ok_nxt   = 1'b0;
                has_start_nxt = 1'b0;
                run_nxt       = '0;
              end else begin
                prev_ok_nxt = 1'b1;
                if (contig && has_start_r) begin
                  run_nxt = run_r + LEN_W'(1);
                end else if (start_ok) begin
                  start_nxt     = j_r;
                  has_start_nxt = 1'b1;
                  run_nxt       = LEN_W'(1);
                end else begin
                  has_start_nxt = 1'b0;
                  run_nxt       = '0;
                end
              end
              prev_frame_nxt = e_frame;
              if (has_start_nxt && run_nxt == len_r) begin
                // Run complete: go back to its first entry and claim it.
                found_nxt  = 1'b1;
                phase_nxt  = PH_APPLY;
                j_nxt      = start_nxt;
                remain_nxt = len_r;
              end else begin
                j_nxt = j_r + NW'(1);
              end
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {1'b1, 1'b0, REF_WIDTH'(1), e_frame};
              if (!e_dirty) begin
                zeroed_nxt = zeroed_r - CNT_W'(1);
              end
              unused_nxt = unused_r - CNT_W'(1);
              if (remain_r == len_r) begin
                res_frame_nxt = e_frame;
              end
              j_nxt      = j_r + NW'(1);
              remain_nxt = remain_r - LEN_W'(1);
            end
          end

          CMD_RETURN, CMD_MARK, CMD_INCREF, CMD_READREF: begin
            if (phase_r == PH_APPLY) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {e_dirty, (dec_ref == '0) ? 1'b1 : e_free, dec_ref, e_frame};
              if (dec_ref == '0) begin
                unused_nxt = unused_r + CNT_W'(1);
              end
              j_nxt      = j_r + NW'(1);
              remain_nxt = remain_r - LEN_W'(1);
            end else if (e_frame == key_r) begin
              found_nxt = 1'b1;
              case (cmd_r)
                CMD_RETURN: begin
                  phase_nxt  = PH_APPLY;
                  remain_nxt = len_r;
                end
                CMD_MARK: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {1'b1, 1'b0, REF_WIDTH'(1), e_frame};
                  if (!e_dirty) begin
                    zeroed_nxt = zeroed_r - CNT_W'(1);
                  end
                  unused_nxt = unused_r - CNT_W'(1);
                  state_nxt  = S_FIN;
                end
                CMD_INCREF: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {e_dirty, e_free, e_ref + REF_WIDTH'(1), e_frame};
                  state_nxt   = S_FIN;
                end
                default: begin
                  val_nxt   = VAL_W'(32'(signed'(e_ref)));
                  state_nxt = S_FIN;
                end
              endcase
            end else begin
              j_nxt = j_r + NW'(1);
            end
          end

          CMD_ZERO: begin
            if (e_free && e_dirty) begin
              if (pend_v_r && !res_ready) begin
                // The previous frame's result has not left yet; hold here.
                state_nxt = S_EV;
              end else begin
                res_valid   = pend_v_r;
                res         = pend_r;
                mem_wr_en   = 1'b1;
                mem_wr_data = {1'b0, e_free, e_ref, e_frame};
                zeroed_nxt  = zeroed_r + CNT_W'(1);
                cnt_nxt     = cnt_r + CW'(1);
                pend_v_nxt  = 1'b1;
                pend_nxt    = '{status: STS_OK, frame: e_frame,
                                value: VAL_W'(cnt_r + CW'(1)), unused: unused_r,
                                zeroed: zeroed_r + CNT_W'(1), last: 1'b0};
                j_nxt       = j_r + NW'(1);
              end
            end else begin
              j_nxt = j_r + NW'(1);
            end
          end

          CMD_COUNT: begin
            if (e_ref == '0 && (dsel_r[1] || e_dirty == dsel_r[0])) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            j_nxt = j_r + NW'(1);
          end

          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_FIN: begin
        res_valid = 1'b1;
        case (cmd_r)
          CMD_ALLOC: begin
            if (found_r) begin
              res.frame = res_frame_r;
            end else begin
              res.status = STS_NOFRAME;
            end
          end
          CMD_RETURN, CMD_MARK, CMD_INCREF: begin
            if (!found_r) begin
              res.status = STS_NOTFOUND;
            end
          end
          CMD_READREF: begin
            if (found_r) begin
              res.value = val_r;
            end else begin
              res.status = STS_NOTFOUND;
              res.value  = '1;
            end
          end
          CMD_ZERO: begin
            if (pend_v_r) begin
              res      = pend_r;
              res.last = 1'b1;
            end else begin
              res.status = STS_NOFRAME;
            end
          end
          CMD_COUNT: begin
            res.value = (32'(cnt_r) > SAT_MAX) ? VAL_W'(SAT_MAX) : VAL_W'(cnt_r);
          end
          default: begin
          end
        endcase
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      unused_r      <= '0;
      zeroed_r      <= '0;
      pend_v_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      unused_r      <= unused_nxt;
      zeroed_r      <= zeroed_nxt;
      pend_v_r      <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r      <= phase_nxt;
    cmd_r        <= cmd_nxt;
    pend_r       <= pend_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    remain_r     <= remain_nxt;
    run_r        <= run_nxt;
    zonly_r      <= zonly_nxt;
    zlim_r       <= zlim_nxt;
    dsel_r       <= dsel_nxt;
    live_r       <= live_nxt;
    j_r          <= j_nxt;
    start_r      <= start_nxt;
    has_start_r  <= has_start_nxt;
    prev_ok_r    <= prev_ok_nxt;
    prev_frame_r <= prev_frame_nxt;
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    val_r        <= val_nxt;
    res_frame_r  <= res_frame_nxt;
  end

  // The scan never reads an entry in the same cycle that it writes it.
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd_en && mem_wr_en && mem_rd_addr == mem_wr_addr))
    else $error("frame table read and write hit the same entry");

  // Entry evaluation only follows a read issue or a stalled evaluation.
  a_ev_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EV |-> $past(state_r) == S_RD || $past(state_r) == S_EV)
    else $error("entry evaluated without a table read");

  // A zero-dirty command never marks more frames than its limit.
  a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && cmd_r == CMD_ZERO |-> cnt_r <= CW'(zlim_r))
    else $error("zero burst exceeded its limit");

  // An accepted request always starts work on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("request accepted but engine stayed idle");

endmodule

// ===== rtl/page_frame_allocator_core.sv =====
// Page frame allocator. Every request except load walks the frame table in
// index order through its single read port, each entry in two steps (issue
// the read, then evaluate and write back); allocate and return then walk the
// claimed or released run once more to update it. Requests are taken one at
// a time; results leave through an output register, so the engine finishes a
// request while its result waits. Zero dirty answers with one result per
// frame it cleans, the last one flagged on out_tlast, or with one no-frame
// result if it cleans none; its scan stalls while a result cannot move on.
// Depends on pfa_pkg, pfa_engine, pfa_mem and pfa_out_buf.
module page_frame_allocator_core #(
  parameter int TABLE_DEPTH    = 4096,
  parameter int REF_WIDTH      = 16,
  parameter int MAX_ZERO_BURST = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,    // entry_count
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index[11:0], frame_number[51:12], entry_free[52], order[56:53],
  // clean_only[57], zero_limit[64:58], dirty_select[66:65], zero fill
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,       // command
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_out[39:0], value[55:40], unused_frames[68:56],
  // zeroed_frames[81:69], zero fill
  output logic [87:0] out_tdata,
  output logic [1:0]  out_tuser,      // status
  output logic        out_tlast
);
  import pfa_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = FRAME_W + REF_WIDTH + 2;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [EW-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [EW-1:0] mem_wr_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_res;

  pfa_engine #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .REF_WIDTH     (REF_WIDTH),
    .MAX_ZERO_BURST(MAX_ZERO_BURST),
    .AW            (AW),
    .EW            (EW)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_command     (in_tuser),
    .in_entry_index (in_tdata[11:0]),
    .in_frame_number(in_tdata[51:12]),
    .in_entry_free  (in_tdata[52]),
    .in_order       (in_tdata[56:53]),
    .in_clean_only  (in_tdata[57]),
    .in_zero_limit  (in_tdata[64:58]),
    .in_dirty_select(in_tdata[66:65]),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  pfa_mem #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(EW),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  pfa_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {6'd0, out_res.zeroed, out_res.unused, out_res.value, out_res.frame};
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

endmodule
